[design/ilid_pkg.sv]
`default_nettype none

package ilid_pkg;

  // Default list capacity.
  localparam int DEPTH_DEF = 64;

  // Field widths of a transaction.
  localparam int MODE_W  = 3;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int PLACE_W = 6;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  // Stream data widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Bit offsets of the result fields within the output tdata.
  localparam int OUT_PLACE_LSB = VALUE_W;
  localparam int OUT_COUNT_LSB = OUT_PLACE_LSB + PLACE_W;
  localparam int OUT_STAT_LSB  = OUT_COUNT_LSB + COUNT_W;

  // Operation codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_END   = 3'd0,
    MODE_INS_POS   = 3'd1,
    MODE_DEL_FIRST = 3'd2,
    MODE_DEL_POS   = 3'd3,
    MODE_DEL_LAST  = 3'd4
  } mode_t;

  // Status codes.
  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_OUT
  } state_t;

endpackage

`default_nettype wire

[design/ilid_ram.sv]
`default_nettype none

module ilid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/indexed_list_insert_delete.sv]
// Each change that succeeds first moves the affected elements one place
// through the store, one read and one write per moved element, then emits
// the list; a refused or ignored operation only emits it. Emission reads each
// element from the store, loads the output register and hands it over, held
// by any stall on the output side; an empty list gives one result. The block
// takes one operation at a time.
// Synchronous reset empties the list and returns the sequencer to idle.
`default_nettype none

module indexed_list_insert_delete
  import ilid_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // mode[2:0], position[9:3], item_value[41:10], zero pad above
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // element_value[31:0], element_place[37:32], list_count[44:38],
  // status[46:45], zero pad above
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        m_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int PW = (AW > PLACE_W) ? AW : PLACE_W;

  // Input fields.
  logic [MODE_W-1:0]  in_mode;
  logic [POS_W-1:0]   in_pos;
  logic [VALUE_W-1:0] in_value;

  assign in_mode  = s_tdata[MODE_W-1:0];
  assign in_pos   = s_tdata[MODE_W+POS_W-1:MODE_W];
  assign in_value = s_tdata[MODE_W+POS_W+VALUE_W-1:MODE_W+POS_W];

  // Sequencer and list registers.
  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      at, at_next;
  logic [VALUE_W-1:0] val, val_next;
  status_t            stat, stat_next;
  logic [AW-1:0]      k, k_next;

  // Output register.
  logic [VALUE_W-1:0] o_val, o_val_next;
  logic [PLACE_W-1:0] o_place, o_place_next;
  logic [COUNT_W-1:0] o_cnt, o_cnt_next;
  status_t            o_stat, o_stat_next;
  logic               o_last, o_last_next;

  // Store port signals.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // Widened views for compares and masked output fields.
  logic [XW-1:0] pos_x, cnt_x;
  logic [PW-1:0] k_px;
  logic [CW-1:0] idx_dec, idx_inc, k_inc;
  logic          full, empty;

  assign pos_x   = XW'(in_pos);
  assign cnt_x   = XW'(count);
  assign k_px    = PW'(k);
  assign idx_dec = idx - CW'(1);
  assign idx_inc = idx + CW'(1);
  assign k_inc   = CW'(k) + CW'(1);
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);

  ilid_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    at      <= at_next;
    val     <= val_next;
    stat    <= stat_next;
    k       <= k_next;
    o_val   <= o_val_next;
    o_place <= o_place_next;
    o_cnt   <= o_cnt_next;
    o_stat  <= o_stat_next;
    o_last  <= o_last_next;
  end

  // Sequencer: decode, shift the store one element at a time, then emit.
  always_comb begin
    state_next   = state;
    count_next   = count;
    idx_next     = idx;
    at_next      = at;
    val_next     = val;
    stat_next    = stat;
    k_next       = k;
    o_val_next   = o_val;
    o_place_next = o_place;
    o_cnt_next   = o_cnt;
    o_stat_next  = o_stat;
    o_last_next  = o_last;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          val_next   = in_value;
          k_next     = '0;
          stat_next  = ST_OK;
          state_next = S_EMIT_RD;
          case (in_mode)
            MODE_INS_END: begin
              if (full) begin
                stat_next = ST_FULL;
              end else begin
                idx_next   = count;
                at_next    = count;
                state_next = S_INS_RD;
              end
            end
            MODE_INS_POS: begin
              if (full) begin
                stat_next = ST_FULL;
              end else if (pos_x > cnt_x) begin
                stat_next = ST_RANGE;
              end else begin
                idx_next   = count;
                at_next    = CW'(in_pos);
                state_next = S_INS_RD;
              end
            end
            MODE_DEL_FIRST: begin
              if (empty) begin
                stat_next = ST_EMPTY;
              end else begin
                idx_next   = '0;
                state_next = S_DEL_RD;
              end
            end
            MODE_DEL_POS: begin
              if (empty) begin
                stat_next = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                stat_next = ST_RANGE;
              end else begin
                idx_next   = CW'(in_pos);
                state_next = S_DEL_RD;
              end
            end
            MODE_DEL_LAST: begin
              if (empty) begin
                stat_next = ST_EMPTY;
              end else begin
                idx_next   = count - CW'(1);
                state_next = S_DEL_RD;
              end
            end
            default: begin
              stat_next = ST_OK;
            end
          endcase
        end
      end

      // Insert: move elements up from the tail, then drop the value in.
      S_INS_RD: begin
        if (idx > at) begin
          ram_raddr  = idx_dec[AW-1:0];
          state_next = S_INS_WR;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = at[AW-1:0];
          ram_wdata  = val;
          count_next = count + CW'(1);
          state_next = S_EMIT_RD;
        end
      end
      S_INS_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = idx[AW-1:0];
        ram_wdata  = ram_rdata;
        idx_next   = idx_dec;
        state_next = S_INS_RD;
      end

      // Delete: move elements down over the gap, then shorten the list.
      S_DEL_RD: begin
        if (idx_inc < count) begin
          ram_raddr  = idx_inc[AW-1:0];
          state_next = S_DEL_WR;
        end else begin
          count_next = count - CW'(1);
          state_next = S_EMIT_RD;
        end
      end
      S_DEL_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = idx[AW-1:0];
        ram_wdata  = ram_rdata;
        idx_next   = idx_inc;
        state_next = S_DEL_RD;
      end

      // Emission: read one element, load the output register, hand it over.
      S_EMIT_RD: begin
        if (empty) begin
          o_val_next   = '0;
          o_place_next = '0;
          o_cnt_next   = '0;
          o_stat_next  = stat;
          o_last_next  = 1'b1;
          state_next   = S_EMIT_OUT;
        end else begin
          ram_raddr  = k;
          state_next = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        o_val_next   = ram_rdata;
        o_place_next = k_px[PLACE_W-1:0];
        o_cnt_next   = cnt_x[COUNT_W-1:0];
        o_stat_next  = stat;
        o_last_next  = (k_inc == count);
        state_next   = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (m_tready) begin
          if (o_last) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k_inc[AW-1:0];
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Stream ports.
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_EMIT_OUT);
  assign m_tlast  = o_last;
  assign m_tdata  = {{(OUT_TDATA_W - VALUE_W - PLACE_W - COUNT_W - STAT_W){1'b0}},
                     o_stat, o_cnt, o_place, o_val};

endmodule

`default_nettype wire

[design/ilid_checker.sv]
`default_nettype none

module ilid_checker
  import ilid_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic                   m_tlast
);

  // A stalled result holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // The block never takes an operation while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while result pending");

  // An accepted operation keeps the input side closed in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready straight after a transaction");

  // The run stays open until its last result has been taken.
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("input ready in the middle of a run");

  // An empty list is reported as one result that closes the run.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[OUT_STAT_LSB-1:OUT_COUNT_LSB] == '0) |->
      m_tlast && (m_tdata[OUT_COUNT_LSB-1:OUT_PLACE_LSB] == '0))
    else $error("empty list result malformed");

endmodule

bind indexed_list_insert_delete ilid_checker u_ilid_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ilid_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_OPS  = 390;
  localparam int SETTLE_WAIT = 400;

  // Mode codes that the block must ignore.
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    bit                 wait_drain;
  } list_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PLACE_W-1:0] place;
    logic [COUNT_W-1:0] count;
    status_t            status;
    logic               last;
  } list_elem_t;

  typedef enum int {GROW, SHRINK, MIXED} mix_phase_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  // Operations waiting to be sent and list elements waiting to come back.
  list_op_t   pending_ops[$];
  list_elem_t expected_elems[$];
  list_op_t   cur_op;
  list_elem_t got_elem;
  list_elem_t want_elem;

  // Mirror of the list held by the block.
  logic [VALUE_W-1:0] list_mirror[DEPTH_DEF];
  int unsigned        mirror_len = 0;
  int unsigned        planned_len = 0;

  int error_count   = 0;
  int ops_accepted  = 0;
  int elems_checked = 0;
  int peak_len      = 0;
  int status_hits[4] = '{0, 0, 0, 0};
  int cycle_count   = 0;

  // A stretch of operations during which neither side idles.
  wire calm = (ops_accepted >= 180) && (ops_accepted < 240);

  indexed_list_insert_delete #(.DEPTH(DEPTH_DEF)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Opens a gap at the given place and writes the new value into it.
  function automatic status_t mirror_insert(input int unsigned at, input logic [VALUE_W-1:0] v);
    if (mirror_len >= DEPTH_DEF) return ST_FULL;
    if (at > mirror_len) return ST_RANGE;
    for (int unsigned i = mirror_len; i > at; i--) list_mirror[i] = list_mirror[i-1];
    list_mirror[at] = v;
    mirror_len++;
    return ST_OK;
  endfunction

  // Closes the gap left by the removed element.
  function automatic status_t mirror_delete(input int unsigned at);
    if (mirror_len == 0) return ST_EMPTY;
    if (at >= mirror_len) return ST_RANGE;
    for (int unsigned i = at; i + 1 < mirror_len; i++) list_mirror[i] = list_mirror[i+1];
    mirror_len--;
    return ST_OK;
  endfunction

  // Applies one operation to the mirror and queues the whole list it emits.
  task automatic apply_list_op(input list_op_t op);
    status_t    st;
    list_elem_t e;
    st = ST_OK;
    case (op.mode)
      MODE_INS_END:   st = mirror_insert(mirror_len, op.value);
      MODE_INS_POS:   st = mirror_insert(op.position, op.value);
      MODE_DEL_FIRST: st = mirror_delete(0);
      MODE_DEL_POS:   st = mirror_delete(op.position);
      MODE_DEL_LAST:  st = (mirror_len == 0) ? ST_EMPTY : mirror_delete(mirror_len - 1);
      default:        st = ST_OK;
    endcase
    status_hits[st]++;
    if (mirror_len > peak_len) peak_len = mirror_len;
    if (mirror_len == 0) begin
      e.value  = '0;
      e.place  = '0;
      e.count  = '0;
      e.status = st;
      e.last   = 1'b1;
      expected_elems.push_back(e);
    end else begin
      for (int unsigned k = 0; k < mirror_len; k++) begin
        e.value  = list_mirror[k];
        e.place  = PLACE_W'(k);
        e.count  = COUNT_W'(mirror_len);
        e.status = st;
        e.last   = (k + 1 == mirror_len);
        expected_elems.push_back(e);
      end
    end
  endtask

  // Queues an operation and tracks the list length it will leave behind.
  task automatic push_op(input logic [MODE_W-1:0] mode, input int pos,
                         input logic [VALUE_W-1:0] v, input bit drain);
    list_op_t op;
    op.mode       = mode;
    op.position   = POS_W'(pos);
    op.value      = v;
    op.wait_drain = drain;
    pending_ops.push_back(op);
    case (mode)
      MODE_INS_END:
        if (planned_len < DEPTH_DEF) planned_len++;
      MODE_INS_POS:
        if (planned_len < DEPTH_DEF && op.position <= planned_len) planned_len++;
      MODE_DEL_FIRST, MODE_DEL_LAST:
        if (planned_len > 0) planned_len--;
      MODE_DEL_POS:
        if (planned_len > 0 && op.position < planned_len) planned_len--;
      default: ;
    endcase
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-placed inserts and deletes, weighted by phase, with some
  // bad positions and ignored modes mixed in.
  task automatic queue_random_op(input mix_phase_t phase, input bit drain);
    int                ins_share;
    int                pos;
    int                len;
    logic [MODE_W-1:0] mode;
    len = planned_len;
    pos = $urandom_range(0, 127);
    case (phase)
      GROW:    ins_share = 80;
      SHRINK:  ins_share = 15;
      default: ins_share = 50;
    endcase
    if ($urandom_range(0, 99) < 3) begin
      mode = MODE_UNUSED_LO + MODE_W'($urandom_range(0, 2));
    end else if ($urandom_range(0, 99) < ins_share) begin
      if ($urandom_range(0, 1) == 0) begin
        mode = MODE_INS_END;
      end else begin
        mode = MODE_INS_POS;
        if ($urandom_range(0, 99) < 85) pos = $urandom_range(0, len);
        else pos = $urandom_range(len + 1, 127);
      end
    end else begin
      case ($urandom_range(0, 3))
        0: mode = MODE_DEL_FIRST;
        1: mode = MODE_DEL_LAST;
        default: begin
          mode = MODE_DEL_POS;
          if (len > 0 && $urandom_range(0, 99) < 85) pos = $urandom_range(0, len - 1);
          else pos = $urandom_range(len, 127);
        end
      endcase
    end
    push_op(mode, pos, pick_value(), drain);
  endtask

  task automatic report_diff(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
    error_count++;
  endtask

  // Sender: presents queued operations and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_list_op(cur_op);
        ops_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() != 0
            && !(pending_ops[0].wait_drain && expected_elems.size() != 0)
            && (calm || $urandom_range(0, 99) >= 34)) begin
          cur_op = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= IN_TDATA_W'({cur_op.value, cur_op.position, cur_op.mode});
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random outside the calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= 34);
    end
  end

  // Checks each output transaction against the oldest expected element.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_elem.value  = m_tdata[VALUE_W-1:0];
      got_elem.place  = m_tdata[OUT_PLACE_LSB +: PLACE_W];
      got_elem.count  = m_tdata[OUT_COUNT_LSB +: COUNT_W];
      got_elem.status = m_tdata[OUT_STAT_LSB +: STAT_W];
      got_elem.last   = m_tlast;
      if (expected_elems.size() == 0) begin
        $display("%0t: unexpected element, expected none, got value %h place %0d",
                 $time, got_elem.value, got_elem.place);
        error_count++;
      end else begin
        want_elem = expected_elems.pop_front();
        elems_checked++;
        if (got_elem.value !== want_elem.value)
          report_diff("element_value", want_elem.value, got_elem.value);
        if (got_elem.place !== want_elem.place)
          report_diff("element_place", 32'(want_elem.place), 32'(got_elem.place));
        if (got_elem.count !== want_elem.count)
          report_diff("list_count", 32'(want_elem.count), 32'(got_elem.count));
        if (got_elem.status !== want_elem.status)
          report_diff("status", 32'(want_elem.status), 32'(got_elem.status));
        if (got_elem.last !== want_elem.last)
          report_diff("last_of_run", 32'(want_elem.last), 32'(got_elem.last));
      end
    end
  end

  // Guards against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Builds the stimulus, then waits for the list traffic to finish.
  initial begin
    mix_phase_t phase;
    int         queued;
    int         phase_left;
    int         edge_tries;
    bit         drain;

    // Deletes of every kind on an empty list, then a bad insert position.
    push_op(MODE_DEL_FIRST, 0, '0, 1'b0);
    push_op(MODE_DEL_POS, 0, '0, 1'b0);
    push_op(MODE_DEL_LAST, 0, '0, 1'b0);
    push_op(MODE_DEL_POS, 127, '0, 1'b0);
    push_op(MODE_INS_POS, 1, 32'h1234_5678, 1'b0);
    // Build a short list from the front, the end and the middle.
    push_op(MODE_INS_POS, 0, 32'h7FFF_FFFF, 1'b0);
    push_op(MODE_INS_END, 0, 32'h8000_0000, 1'b0);
    push_op(MODE_INS_END, 127, '0, 1'b0);
    push_op(MODE_INS_POS, 3, '1, 1'b0);
    push_op(MODE_INS_POS, 1, 32'h5555_5555, 1'b0);
    push_op(MODE_INS_POS, 127, 32'hAAAA_AAAA, 1'b0);
    push_op(MODE_INS_POS, 64, 32'h0F0F_0F0F, 1'b0);
    push_op(MODE_DEL_POS, 5, '0, 1'b0);
    push_op(MODE_DEL_POS, 2, '0, 1'b0);
    // Ignored modes leave the list as it is.
    push_op(MODE_UNUSED_LO, 42, 32'hDEAD_BEEF, 1'b0);
    push_op(MODE_UNUSED_LO + 3'd1, 85, '1, 1'b0);
    push_op(MODE_UNUSED_HI, 127, 32'h8000_0000, 1'b0);
    // Empty the list again, one delete removing the only element, then delete once more on the empty list.
    push_op(MODE_DEL_FIRST, 0, '0, 1'b0);
    push_op(MODE_DEL_LAST, 0, '0, 1'b0);
    push_op(MODE_DEL_POS, 0, '0, 1'b0);
    push_op(MODE_DEL_LAST, 0, '0, 1'b0);
    push_op(MODE_DEL_POS, 0, '0, 1'b0);

    // Random part: fill to capacity, drain to empty, then churn.
    phase      = GROW;
    queued     = 0;
    phase_left = 0;
    edge_tries = 0;
    drain      = 1'b1;
    while (queued < RANDOM_OPS) begin
      queue_random_op(phase, drain);
      drain = 1'b0;
      queued++;
      case (phase)
        GROW: begin
          if (planned_len == DEPTH_DEF) begin
            edge_tries++;
            if (edge_tries >= 6) begin
              phase      = SHRINK;
              edge_tries = 0;
              drain      = 1'b1;
            end
          end
        end
        SHRINK: begin
          if (planned_len == 0) begin
            edge_tries++;
            if (edge_tries >= 4) begin
              phase      = MIXED;
              phase_left = $urandom_range(20, 40);
              edge_tries = 0;
              drain      = 1'b1;
            end
          end
        end
        default: begin
          phase_left--;
          if (phase_left <= 0) begin
            phase = GROW;
            drain = 1'b1;
          end
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("Sent %0d operations: %0d ok, %0d full, %0d empty, %0d bad position.",
             ops_accepted, status_hits[ST_OK], status_hits[ST_FULL],
             status_hits[ST_EMPTY], status_hits[ST_RANGE]);
    $display("Checked %0d list elements; the list grew to %0d entries at most.",
             elems_checked, peak_len);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
design/ilid_pkg.sv
design/ilid_ram.sv
design/indexed_list_insert_delete.sv
design/ilid_checker.sv
sim/tb.sv
